### rtl/wbps_pkg.sv
package wbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 6;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_WORDS   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;

    localparam logic [BYTE_W-1:0] WILDCARD = 8'h00;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] t_pattern;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] match_offset;
    } t_out;

    // pattern aligned to the window cells: cell j compares against pattern byte len-1-j
    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [MAX_PATTERN-1:0] use_mask;
        t_pattern               cell_pat;
    } t_cfg;

endpackage

### rtl/wbps_cfg.sv
module wbps_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output wbps_pkg::t_cfg                    o_cfg
);

    logic [wbps_pkg::NUM_WORDS-1:0][wbps_pkg::CFG_DATA_W-1:0] r_words;
    logic [wbps_pkg::LEN_W-1:0]                                 r_len;
    logic [wbps_pkg::LEN_W-1:0]                                 eff_len;
    wbps_pkg::t_pattern                                         pat_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_len   <= wbps_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wbps_pkg::REG_PATTERN_0: r_words[0] <= i_cfg_data;
                wbps_pkg::REG_PATTERN_1: r_words[1] <= i_cfg_data;
                wbps_pkg::REG_PATTERN_2: r_words[2] <= i_cfg_data;
                wbps_pkg::REG_PATTERN_3: r_words[3] <= i_cfg_data;
                wbps_pkg::REG_LENGTH:    r_len      <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, anything past the window acts as the full window
    always_comb begin
        if (r_len == '0) begin
            eff_len = wbps_pkg::LEN_W'(1);
        end else if (r_len > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN)) begin
            eff_len = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    assign pat_bytes = wbps_pkg::t_pattern'(r_words);

    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] idx;
        o_cfg.len = eff_len;
        for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin
            idx = eff_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
            o_cfg.use_mask[j] = (wbps_pkg::LEN_W'(j) < eff_len);
            o_cfg.cell_pat[j] = pat_bytes[idx[wbps_pkg::IDX_W-1:0]];
        end
    end

endmodule

### rtl/wbps_cell.sv
module wbps_cell (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic [wbps_pkg::BYTE_W-1:0]    i_byte,
    input  logic [wbps_pkg::BYTE_W-1:0]    i_pat,
    input  logic                           i_use,
    output logic [wbps_pkg::BYTE_W-1:0]    o_byte,
    output logic                           o_hit
);

    logic [wbps_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_use || (i_pat == wbps_pkg::WILDCARD) || (r_byte == i_pat);

endmodule

### rtl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search. Takes one byte per clock and keeps the most recent
// 32 bytes in a chain of window cells; each cell compares its byte against its
// pattern byte (0x00 matches anything) and the hits are combined the cycle after
// the byte enters. The first complete match inside the stream is kept, and the byte
// marked last yields one result (found, offset of the first matching byte) that moves
// from the stage-1 registers to the output register. A new byte can be accepted every
// cycle while a result waits; input stalls only when the last byte of a stream finds
// the output register still full. Configuration writes take effect at once and must
// be made between streams. The byte counter saturates at 0xFFFFFFFF.
module wildcard_byte_pattern_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wbps_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wbps_pkg::t_out                    o_out,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wbps_pkg::t_cfg cfg;

    logic [wbps_pkg::MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] cell_byte;
    logic [wbps_pkg::MAX_PATTERN-1:0]                       cell_hit;

    logic [wbps_pkg::COUNT_W-1:0]  r_count;
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic                          r_s1_exact;
    logic [wbps_pkg::COUNT_W-1:0]  r_s1_count;
    logic                          r_seen;
    logic [wbps_pkg::COUNT_W-1:0]  r_first;
    logic                          r_out_valid;
    wbps_pkg::t_out                r_out;

    logic                          in_fire;
    logic                          s1_go;
    logic                          exact;
    logic                          hit;
    logic [wbps_pkg::COUNT_W-1:0]  len_ext;
    logic [wbps_pkg::COUNT_W-1:0]  hit_offset;

    wbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    for (genvar j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin : g_cell
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (in_fire),
            .i_byte  ((j == 0) ? i_in.data_byte : cell_byte[(j == 0) ? 0 : j - 1]),
            .i_pat   (cfg.cell_pat[j]),
            .i_use   (cfg.use_mask[j]),
            .o_byte  (cell_byte[j]),
            .o_hit   (cell_hit[j])
        );
    end

    // a last byte moves on only when the output register can take its result
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in_valid && o_in_ready;

    assign exact      = (r_count != '1);
    assign len_ext    = wbps_pkg::COUNT_W'(cfg.len);
    assign hit_offset = r_s1_count - len_ext;
    // window cells past the stream start are stale but only when count < len
    assign hit = r_s1_exact && !r_seen && (r_s1_count >= len_ext) && (&cell_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_fire) begin
            if (i_in.last_byte) begin
                r_count <= '0;
            end else if (exact) begin
                r_count <= r_count + wbps_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last  <= i_in.last_byte;
            r_s1_exact <= exact;
            r_s1_count <= exact ? r_count + wbps_pkg::COUNT_W'(1) : r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_first <= '0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_seen  <= 1'b0;
                r_first <= '0;
            end else if (hit) begin
                r_seen  <= 1'b1;
                r_first <= hit_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out.found <= r_seen || hit;
            if (r_seen) begin
                r_out.match_offset <= r_first;
            end else if (hit) begin
                r_out.match_offset <= hit_offset;
            end else begin
                r_out.match_offset <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/wbps_checker.sv
module wbps_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  wbps_pkg::t_in                     i_in,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  wbps_pkg::t_out                    o_out
);

    // a waiting result holds until the transaction completes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |-> o_out.match_offset == '0)
        else $error("offset not zero without a match");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // results only follow a last-byte transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready && i_in.last_byte) ##1
        !(i_in_valid && o_in_ready && i_in.last_byte) |=> !o_out_valid || $past(o_out_valid))
        else $error("result without a last byte");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

### tb/sv/wildcard_byte_pattern_search_tb.sv
module wildcard_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int GAP_MAX      = 11;
    localparam int SETTLE_CYC   = 4;
    localparam int DRAIN_CYC    = 8;
    localparam int IDLE_LIMIT   = 500;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [CFG_IDX_W-1:0]  t_reg_idx;
    typedef logic [CFG_DATA_W-1:0] t_reg_data;

    // one line of the directed table: a register write or a byte transaction
    typedef struct {
        bit        is_cfg;
        t_reg_idx  idx;
        t_reg_data data;
        t_byte     b;
        logic      last;
        bit        typed;
        t_out      res;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in       i_in        = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_we    = 1'b0;
    t_reg_idx  i_cfg_index = '0;
    t_reg_data i_cfg_data  = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out      o_out;

    // shadow of the pattern registers and of the scan state
    t_reg_data    pat_word [NUM_WORDS];
    logic [LEN_W-1:0] pat_len;
    t_byte        win_bytes [MAX_PATTERN];
    logic [COUNT_W-1:0] scanned;
    logic         hit_seen;
    logic [COUNT_W-1:0] hit_offset;

    t_out pending_results [$];
    bit   typed_valid = 1'b0;
    t_out typed_res   = '0;

    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    int rx_stall   = 0;

    int bytes_in      = 0;
    int idle_cycles   = 0;
    int errors        = 0;
    int results_seen  = 0;
    int results_found = 0;
    int streams_sent  = 0;
    int reg_writes    = 0;

    wildcard_byte_pattern_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_len();
        int l = pat_len;
        if (l == 0) l = 1;
        if (l > MAX_PATTERN) l = MAX_PATTERN;
        return l;
    endfunction

    function automatic t_byte pat_byte(int i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic void clear_scan();
        foreach (win_bytes[k]) win_bytes[k] = '0;
        scanned    = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    // advance the scan by one byte; returns 1 when the byte closes a stream
    function automatic bit scan_byte(input t_in item, output t_out res);
        int l;
        bit exact;
        bit hit;
        l = eff_len();
        for (int k = MAX_PATTERN - 1; k > 0; k--) win_bytes[k] = win_bytes[k - 1];
        win_bytes[0] = item.data_byte;
        exact = (scanned != '1);
        if (exact) scanned++;
        if (exact && !hit_seen && scanned >= COUNT_W'(l)) begin
            hit = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (pat_byte(i) != WILDCARD && win_bytes[l - 1 - i] != pat_byte(i)) hit = 1'b0;
            end
            if (hit) begin
                hit_seen   = 1'b1;
                hit_offset = scanned - COUNT_W'(l);
            end
        end
        res = '0;
        if (!item.last_byte) return 1'b0;
        res.found        = hit_seen;
        res.match_offset = hit_seen ? hit_offset : '0;
        clear_scan();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out res;
        t_out exp_res;
        bit   active;
        active = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                active = 1'b1;
                if (scan_byte(i_in, res)) begin
                    if (typed_valid) res = typed_res;
                    pending_results.push_back(res);
                end
                bytes_in++;
            end
            if (o_out_valid && i_out_ready) begin
                active = 1'b1;
                results_seen++;
                if (o_out.found) results_found++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: found=%0d match_offset=%0d",
                           o_out.found, o_out.match_offset);
                    errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_out.found !== exp_res.found) begin
                        $error("found: expected %0d, actual %0d", exp_res.found, o_out.found);
                        errors++;
                    end
                    if (o_out.match_offset !== exp_res.match_offset) begin
                        $error("match_offset: expected %0d, actual %0d",
                               exp_res.match_offset, o_out.match_offset);
                        errors++;
                    end
                end
                rx_stall = rx_no_idle ? 0 : $urandom_range(0, GAP_MAX);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            if (i_cfg_we) active = 1'b1;
        end else begin
            active = 1'b1;
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
        i_out_ready <= (rx_stall == 0);
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input t_reg_data data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx <= REG_PATTERN_3) pat_word[idx[1:0]] = data;
        else if (idx == REG_LENGTH) pat_len = data[LEN_W-1:0];
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results and give the pipeline time to empty before a write
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_byte(input t_byte b, input logic last);
        int gap;
        int target;
        gap = tx_no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= '{data_byte: b, last_byte: last};
        i_in_valid <= 1'b1;
        target = bytes_in + 1;
        wait (bytes_in == target);
        if (last) streams_sent++;
    endtask

    function automatic t_row cfg_row(t_reg_idx idx, t_reg_data data);
        t_row r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_row byte_row(t_byte b, logic last);
        t_row r = '{default: '0};
        r.b    = b;
        r.last = last;
        return r;
    endfunction

    function automatic t_row chk_row(t_byte b, logic last, logic found, int off);
        t_row r = '{default: '0};
        r.b                = b;
        r.last             = last;
        r.typed            = 1'b1;
        r.res.found        = found;
        r.res.match_offset = COUNT_W'(off);
        return r;
    endfunction

    function automatic t_reg_data random_word(int phase);
        t_reg_data w;
        int pick;
        if (phase == 0) return '1;
        if (phase == 1) return '0;
        for (int j = 0; j < CFG_DATA_W / BYTE_W; j++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) w[j * 8 +: 8] = WILDCARD;
            else if (pick == 4) w[j * 8 +: 8] = 8'hFF;
            else w[j * 8 +: 8] = 8'($urandom_range(1, 255));
        end
        return w;
    endfunction

    task automatic configure_phase(input int phase);
        t_reg_data data;
        int len_v;
        int pick;
        for (int r = 0; r < NUM_WORDS; r++) begin
            write_reg(t_reg_idx'(REG_PATTERN_0 + r), random_word(phase));
        end
        pick = $urandom_range(0, 9);
        if (phase == 0) len_v = MAX_PATTERN;
        else if (phase == 1) len_v = $urandom_range(MAX_PATTERN + 1, 2 ** LEN_W - 1);
        else if (phase == 2) len_v = 0;
        else if (pick < 6) len_v = $urandom_range(1, 8);
        else if (pick < 8) len_v = $urandom_range(9, MAX_PATTERN);
        else if (pick == 8) len_v = MAX_PATTERN;
        else len_v = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_PATTERN + 1, 2 ** LEN_W - 1);
        // upper bits of the length register carry noise
        data = {$urandom, $urandom};
        data[LEN_W-1:0] = LEN_W'(len_v);
        write_reg(REG_LENGTH, data);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(t_reg_idx'($urandom_range(REG_LENGTH + 1, 2 ** CFG_IDX_W - 1)),
                      {$urandom, $urandom});
        end
    endtask

    // mostly streams with the pattern planted, some with it broken, some short or pure noise
    task automatic send_stream(output int n);
        t_byte s [$];
        int l;
        int kind;
        int at;
        int j;
        l    = eff_len();
        kind = $urandom_range(0, 9);
        if (kind == 7) n = $urandom_range(1, l);
        else if (kind >= 8) n = $urandom_range(1, 40);
        else n = l + $urandom_range(0, 12);
        if (kind < 7 && $urandom_range(0, 9) == 0) n += $urandom_range(0, 60);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) s.push_back(t_byte'($urandom_range(0, 255)));
            else s.push_back(pat_byte($urandom_range(0, l - 1)));
        end
        if (kind <= 6 && n >= l) begin
            at = $urandom_range(0, n - l);
            for (int i = 0; i < l; i++) begin
                if (pat_byte(i) != WILDCARD) s[at + i] = pat_byte(i);
            end
            if (kind == 6) begin
                j = $urandom_range(0, l - 1);
                s[at + j] = s[at + j] ^ t_byte'($urandom_range(1, 255));
            end
        end
        tx_no_idle = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++) send_byte(s[i], i == n - 1);
    endtask

    initial begin : stimulus
        t_row dir_tab [$];
        int rand_items;
        int budget;
        int n;
        int phase;
        foreach (pat_word[w]) pat_word[w] = '0;
        pat_len = LEN_W'(1);
        clear_scan();
        dir_tab = '{
            // reset pattern: one wildcard byte matches anything
            chk_row(8'hFF, 1'b1, 1'b1, 0),
            chk_row(8'h00, 1'b1, 1'b1, 0),
            cfg_row(REG_PATTERN_0, 64'hAB),
            byte_row(8'h00, 1'b0),
            byte_row(8'hFF, 1'b0),
            chk_row(8'hAB, 1'b1, 1'b1, 2),
            byte_row(8'h12, 1'b0),
            chk_row(8'h34, 1'b1, 1'b0, 0),
            cfg_row(REG_PATTERN_0, 64'hCD00AB),
            cfg_row(REG_LENGTH, 64'd3),
            byte_row(8'hAB, 1'b0),
            byte_row(8'h77, 1'b0),
            chk_row(8'hCD, 1'b1, 1'b1, 0),
            // stream shorter than the pattern
            byte_row(8'hAB, 1'b0),
            chk_row(8'hCD, 1'b1, 1'b0, 0),
            byte_row(8'h55, 1'b0),
            byte_row(8'hAB, 1'b0),
            byte_row(8'hAB, 1'b0),
            byte_row(8'h00, 1'b0),
            byte_row(8'hCD, 1'b0),
            byte_row(8'hCD, 1'b1),
            // zero length acts as one
            cfg_row(REG_LENGTH, 64'd0),
            chk_row(8'hAB, 1'b1, 1'b1, 0),
            cfg_row(t_reg_idx'(REG_LENGTH + 1), '1),
            cfg_row(t_reg_idx'(REG_LENGTH + 3), '1),
            byte_row(8'hAB, 1'b0),
            chk_row(8'h01, 1'b1, 1'b1, 0),
            // oversized length clamps to the full window
            cfg_row(REG_PATTERN_0, '1),
            cfg_row(REG_PATTERN_1, '1),
            cfg_row(REG_PATTERN_2, '1),
            cfg_row(REG_PATTERN_3, '1),
            cfg_row(REG_LENGTH, 64'd63),
            byte_row(8'hFF, 1'b0),
            chk_row(8'hFF, 1'b1, 1'b0, 0)
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) begin
                settle();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                typed_valid = dir_tab[r].typed;
                typed_res   = dir_tab[r].res;
                send_byte(dir_tab[r].b, dir_tab[r].last);
            end
        end
        typed_valid = 1'b0;

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            configure_phase(phase);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            budget = $urandom_range(60, 140);
            while (budget > 0 && rand_items < RANDOM_ITEMS) begin
                send_stream(n);
                budget     -= n;
                rand_items += n;
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("scanned %0d bytes in %0d streams over %0d pattern settings, %0d reg writes",
                 bytes_in, streams_sent, phase + 4, reg_writes);
        $display("checked %0d results, %0d with a match", results_seen, results_found);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
